### rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int ROW_W         = 12;
   localparam logic [ROW_W-1:0] ROW_MAX = 12'd4095;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // register index carried by address bit 2 (byte address 4*i)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam int PIX_W   = 24;
   localparam int SUM_W   = 12;   // up to nine times 255
   localparam int NUM_W   = 13;   // 2*sum + n
   localparam int RECIP_W = 20;
   localparam int RECIP_SHIFT = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic capture;   // latch the accepted item
      logic mem_rd;    // read both line stores
      logic update;    // shift window, write stores, advance counters
      logic load_out;  // finish divide into the output register
   } cmd_type;

   typedef struct packed {
      logic match;     // offered item fits the frame phase
      logic emit;      // current item yields a result
   } status_type;

   // ceil(2^20 / (2n)) for the neighbour counts that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd1:    m = 20'd524288;
         4'd2:    m = 20'd262144;
         4'd3:    m = 20'd174763;
         4'd4:    m = 20'd131072;
         4'd6:    m = 20'd87382;
         4'd9:    m = 20'd58255;
         default: m = 20'd0;
      endcase
      return m;
   endfunction

endpackage

### rtl/core/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core
// Streaming 3x3 box blur over RGB frames, mean over in-frame neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries pixels in raster order (tuser = 0) and, after the frame's
//   last pixel, width + 1 drain ticks (tuser = 1). Items that do not fit the
//   frame phase are taken and dropped. rsp_* carries one blurred pixel per
//   input item from the second line's second item on; tlast marks the frame's last pixel.
//   Items pass one at a time: accept, line-store read (registered RAM port),
//   window update with masked sums, reciprocal multiply into the output
//   register. An item that yields no pixel skips the divide step, and an
//   item that does not fit the frame phase goes no further than accept.
//   A result reaches rsp_* from the output register loaded by the divide step.
//   The output register lets the next item start while a result waits; if
//   the receiver stalls, the divide step holds until the register frees.
//   Reset clears counters and window and sets width 640, height 480; line
//   store contents stay undefined until written and need no clearing.
//   csr_*: register 0 (address 0) image width, register 1 (address 4) height.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    csr_wr;
   cmd_type                 cmd;
   status_type              stat;
   pixel_type               in_pixel, out_pixel;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // unpack and pack payload, red in the low byte
   assign in_pixel.red   = req_tdata[7:0];
   assign in_pixel.green = req_tdata[15:8];
   assign in_pixel.blue  = req_tdata[23:16];
   assign rsp_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

   bb3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bb3_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_tuser),
      .req_pixel  (in_pixel),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .out_pixel  (out_pixel),
      .out_last   (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && stat.match) |=> cmd.mem_rd)
      else $error("accepted item did not start a line-store read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while holding a result");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !stat.emit) |=> !cmd.load_out)
      else $error("result produced for an item that emits nothing");
`endif

endmodule

### rtl/core/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/core/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accept, read line stores, update window, divide, hand off.
// ----------------------------------------------------------------------------
module bb3_ctrl
   import bb3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_SUM  = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && stat.match) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.update = 1'b1;
            state_in   = stat.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register occupancy
   always_comb begin
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/core/bb3_datapath.sv
// ----------------------------------------------------------------------------
// bb3_datapath
// Line stores, 3x3 window, frame counters, masked sums and reciprocal divide.
// ----------------------------------------------------------------------------
module bb3_datapath
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              stat,
   input  logic                    req_action,
   input  pixel_type               req_pixel,
   input  logic [WIDTH_REG_W-1:0]  width_cfg,
   input  logic [HEIGHT_REG_W-1:0] height_cfg,
   output pixel_type               out_pixel,
   output logic                    out_last
);

   localparam int CW = $clog2(MAX_WIDTH);

   pixel_type item_ff;
   pixel_type up_rd, mid_rd;
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic             in_done_ff, in_done_in;
   pixel_type        win_ff [9];
   pixel_type        nwin [9];
   logic [NUM_W-1:0] num_r_ff, num_g_ff, num_b_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic             last_ff;
   logic [31:0]      w_eff, h_eff;
   logic             top, bot, left, right, last;
   logic [1:0]       rows, cols;
   logic [3:0]       n_cnt;
   logic [SUM_W-1:0] sr, sg, sb;
   logic [NUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;

   // clamp frame size
   always_comb begin
      w_eff = 32'(width_cfg);
      if (w_eff < 32'd1) w_eff = 32'd1;
      if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
      h_eff = 32'(height_cfg);
      if (h_eff < 32'd1) h_eff = 32'd1;
      if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
   end

   assign stat.match = (req_action == in_done_ff);
   assign stat.emit  = (in_row_ff >= 12'd2) || (in_row_ff == 12'd1 && in_col_ff != '0);

   // hold the accepted item; drain ticks carry black
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_action ? pixel_type'('0) : req_pixel;
      end
   end

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (in_col_ff),
      .wr_data (mid_rd),
      .rd_en   (cmd.mem_rd),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (in_col_ff),
      .wr_data (item_ff),
      .rd_en   (cmd.mem_rd),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // shifted window, newest column on the right
   always_comb begin
      nwin[0] = win_ff[1]; nwin[1] = win_ff[2]; nwin[2] = up_rd;
      nwin[3] = win_ff[4]; nwin[4] = win_ff[5]; nwin[5] = mid_rd;
      nwin[6] = win_ff[7]; nwin[7] = win_ff[8]; nwin[8] = item_ff;
   end

   // neighbour masks and masked sums
   always_comb begin
      top   = (out_row_ff != '0);
      bot   = (32'(out_row_ff) + 32'd1 < h_eff);
      left  = (out_col_ff != '0);
      right = (32'(out_col_ff) + 32'd1 < w_eff);
      last  = !bot && !right;
      rows  = 2'd1 + 2'(top) + 2'(bot);
      cols  = 2'd1 + 2'(left) + 2'(right);
      n_cnt = 4'(rows) * 4'(cols);
      sr = '0; sg = '0; sb = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!((r == 0 && !top) || (r == 2 && !bot) ||
                  (c == 0 && !left) || (c == 2 && !right))) begin
               sr = sr + SUM_W'(nwin[r*3+c].red);
               sg = sg + SUM_W'(nwin[r*3+c].green);
               sb = sb + SUM_W'(nwin[r*3+c].blue);
            end
         end
      end
   end

   // advance frame counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (32'(in_col_ff) + 32'd1 >= w_eff) begin
         in_col_in = '0;
         if (!in_done_ff && (32'(in_row_ff) + 32'd1 >= h_eff)) in_done_in = 1'b1;
         if (in_row_ff < ROW_MAX) in_row_in = in_row_ff + 1'b1;
      end else begin
         in_col_in = in_col_ff + 1'b1;
      end
      if (stat.emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            in_done_in = 1'b0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (!right) begin
            out_col_in = '0;
            if (out_row_ff < ROW_MAX) out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (cmd.update) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_done_ff <= in_done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         for (int i = 0; i < 9; i++) win_ff[i] <= nwin[i];
      end
   end

   // latch numerators and reciprocal for the divide
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         num_r_ff <= {sr, 1'b0} + NUM_W'(n_cnt);
         num_g_ff <= {sg, 1'b0} + NUM_W'(n_cnt);
         num_b_ff <= {sb, 1'b0} + NUM_W'(n_cnt);
         recip_ff <= recip(n_cnt);
         last_ff  <= last;
      end
   end

   // rounded mean by reciprocal multiply
   assign prod_r = (NUM_W+RECIP_W)'(num_r_ff) * (NUM_W+RECIP_W)'(recip_ff);
   assign prod_g = (NUM_W+RECIP_W)'(num_g_ff) * (NUM_W+RECIP_W)'(recip_ff);
   assign prod_b = (NUM_W+RECIP_W)'(num_b_ff) * (NUM_W+RECIP_W)'(recip_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_pixel.red   <= prod_r[RECIP_SHIFT+7:RECIP_SHIFT];
         out_pixel.green <= prod_g[RECIP_SHIFT+7:RECIP_SHIFT];
         out_pixel.blue  <= prod_b[RECIP_SHIFT+7:RECIP_SHIFT];
         out_last        <= last_ff;
      end
   end

endmodule

### dv/box_blur_3x3_edge_aware_core_test.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core_test
// Self-checking bench for the streaming 3x3 box blur. A short table of
// directed frames runs first. It is followed by extreme frame sizes and then
// by random frames with stray pixels and drain ticks mixed in. Every blurred
// pixel is compared against a behavioral blur that tracks its own line
// stores, window and frame counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_core_test
   import bb3_pkg::*;
();

   localparam int MAXW        = DEF_MAX_WIDTH;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } blur_out_type;

   typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} row_check_type;

   typedef struct {
      bit            drain;
      pixel_type     px;
      row_check_type check;
      blur_out_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // red_in, green_in, blue_in
   logic        req_tuser = 1'b0;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red_out, green_out, blue_out
   logic        rsp_tlast;         // frame_last
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   box_blur_3x3_edge_aware_core uut (.*);

   always #10 clock = ~clock;

   // behavioral blur state
   logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
   pixel_type   upper_line [MAXW];
   pixel_type   middle_line [MAXW];
   pixel_type   window [9];
   int unsigned in_col, in_row, out_col, out_row;
   bit          input_done;

   blur_out_type blurred_due [$];
   int  errors;
   int  item_count;
   int  cycles;
   bit  steady;

   function automatic int unsigned eff_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > MAXW) return MAXW;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height < 1) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic logic [7:0] mean_half_up(int unsigned sum, int unsigned n);
      return 8'((2 * sum + n) / (2 * n));
   endfunction

   // Advance the blur by one accepted item; returns 1 when a pixel comes out.
   function automatic bit blur_predict(input bit drain, input pixel_type px,
                                       output blur_out_type res);
      int unsigned w, h, col, sr, sg, sb, n;
      pixel_type pix, up, mid, v;
      bit emit, top, bot, left, right;
      w = eff_width();
      h = eff_height();
      sr = 0; sg = 0; sb = 0; n = 0;
      res = '0;
      // drop items that do not fit the frame phase
      if (drain != input_done) return 0;
      pix = drain ? '0 : px;
      col = (in_col >= MAXW) ? MAXW - 1 : in_col;
      up  = upper_line[col];
      mid = middle_line[col];
      upper_line[col]  = mid;
      middle_line[col] = pix;
      window[0] = window[1]; window[1] = window[2]; window[2] = up;
      window[3] = window[4]; window[4] = window[5]; window[5] = mid;
      window[6] = window[7]; window[7] = window[8]; window[8] = pix;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         in_col = 0;
         if (!input_done && in_row + 1 >= h) input_done = 1;
         if (in_row < ROW_MAX) in_row++;
      end else begin
         in_col++;
      end
      if (!emit) return 0;
      top   = out_row > 0;
      bot   = out_row + 1 < h;
      left  = out_col > 0;
      right = out_col + 1 < w;
      // sum only the neighbours inside the frame
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && !top) || (r == 2 && !bot)) continue;
            if ((c == 0 && !left) || (c == 2 && !right)) continue;
            v = window[r * 3 + c];
            sr += v.red; sg += v.green; sb += v.blue;
            n++;
         end
      end
      res.red   = mean_half_up(sr, n);
      res.green = mean_half_up(sg, n);
      res.blue  = mean_half_up(sb, n);
      res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (res.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0; input_done = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         if (out_row < ROW_MAX) out_row++;
      end else begin
         out_col++;
      end
      return 1;
   endfunction

   task automatic note_error(input string msg);
      if (errors < 10) $display("ERROR at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("box_blur_3x3_edge_aware_core_test: done, errors");
         $finish;
      end
   end

   // check each result transfer, then pick the next ready
   always @(posedge clock) begin
      blur_out_type exp_px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blurred_due.size() == 0) begin
            note_error($sformatf("unexpected result %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            exp_px = blurred_due.pop_front();
            if (rsp_tdata[7:0] !== exp_px.red || rsp_tdata[15:8] !== exp_px.green ||
                rsp_tdata[23:16] !== exp_px.blue || rsp_tlast !== exp_px.last)
               note_error($sformatf("rgb/last exp %h %h %h %b got %h %h %h %b",
                  exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                  rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast));
         end
      end
      rsp_tready <= !reset && (steady || $urandom_range(99) >= 32);
   end

   // A setup phase, an access phase until pready, then the bus goes idle.
   task automatic csr_access(input bit wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_regs();
      logic [31:0] rd;
      csr_access(1'b0, {REG_IMAGE_WIDTH, 2'b00}, '0, rd);
      if (rd !== 32'(cfg_width)) note_error($sformatf("width reads %0d", rd));
      csr_access(1'b0, {REG_IMAGE_HEIGHT, 2'b00}, '0, rd);
      if (rd !== 32'(cfg_height)) note_error($sformatf("height reads %0d", rd));
   endtask

   // Set the frame size once the block has drained, then read it back.
   task automatic set_frame(input int w, input int h);
      logic [31:0] rd;
      req_tvalid <= 1'b0;
      while (blurred_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_access(1'b1, {REG_IMAGE_WIDTH, 2'b00}, 32'(w), rd);
      cfg_width = WIDTH_REG_W'(w);
      csr_access(1'b1, {REG_IMAGE_HEIGHT, 2'b00}, 32'(h), rd);
      cfg_height = HEIGHT_REG_W'(h);
      check_regs();
   endtask

   // Offer one item, hold it until the transfer, then predict.
   task automatic send_item(input bit drain, input pixel_type px,
                            output bit got, output blur_out_type res);
      int gap;
      gap = (!steady && $urandom_range(99) < 32) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= drain;
      req_tdata  <= {px.blue, px.green, px.red};
      do @(posedge clock); while (!req_tready);
      item_count++;
      got = blur_predict(drain, px, res);
      if (got) blurred_due.push_back(res);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      p = pixel_type'($urandom);
      case ($urandom_range(7))
         0: p.red = 8'hFF;
         1: p.green = 8'h00;
         2: p = '1;
         3: p = '0;
         default: ;
      endcase
      return p;
   endfunction

   // One well-formed frame with stray items sprinkled in.
   task automatic run_frame();
      int w, h;
      bit got;
      blur_out_type res;
      w = eff_width();
      h = eff_height();
      for (int p = 0; p < w * h; p++) begin
         if ($urandom_range(19) == 0) send_item(1'b1, random_pixel(), got, res);
         send_item(1'b0, random_pixel(), got, res);
      end
      for (int d = 0; d <= w; d++) begin
         if ($urandom_range(19) == 0) send_item(1'b0, random_pixel(), got, res);
         send_item(1'b1, random_pixel(), got, res);
      end
   endtask

   function automatic stim_row_type row(input bit drain, input logic [7:0] v,
                                        input row_check_type chk, input bit last);
      stim_row_type s;
      s.drain = drain;
      s.px    = {v, v, v};
      s.check = chk;
      s.want  = {v, v, v, last};
      return s;
   endfunction

   initial begin
      stim_row_type directed [$];
      bit got;
      blur_out_type res;
      int rand_start, w, h;

      for (int i = 0; i < MAXW; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_regs();

      // 3x3 frames: a flat white one and a flat black one, with stray items
      directed = '{
         row(1, 8'h00, CHK_NONE, 0),                              // drain too early
         row(0, 8'hFF, CHK_NONE, 0), row(0, 8'hFF, CHK_NONE, 0),
         row(0, 8'hFF, CHK_NONE, 0), row(0, 8'hFF, CHK_NONE, 0),
         row(0, 8'hFF, CHK_TYPED, 0), row(0, 8'hFF, CHK_TYPED, 0),
         row(0, 8'hFF, CHK_TYPED, 0), row(0, 8'hFF, CHK_TYPED, 0),
         row(0, 8'hFF, CHK_TYPED, 0),
         row(0, 8'h00, CHK_NONE, 0),                              // pixel too late
         row(1, 8'hFF, CHK_TYPED, 0), row(1, 8'hFF, CHK_TYPED, 0),
         row(1, 8'hFF, CHK_TYPED, 0), row(1, 8'hFF, CHK_TYPED, 1),
         row(0, 8'h00, CHK_NONE, 0), row(0, 8'h00, CHK_NONE, 0),
         row(0, 8'h00, CHK_NONE, 0), row(0, 8'h00, CHK_NONE, 0),
         row(0, 8'h00, CHK_TYPED, 0), row(0, 8'h00, CHK_TYPED, 0),
         row(0, 8'h00, CHK_TYPED, 0), row(0, 8'h00, CHK_TYPED, 0),
         row(0, 8'h00, CHK_TYPED, 0),
         row(1, 8'h00, CHK_TYPED, 0), row(1, 8'h00, CHK_TYPED, 0),
         row(1, 8'h00, CHK_TYPED, 0), row(1, 8'h00, CHK_TYPED, 1)
      };
      set_frame(3, 3);
      foreach (directed[i]) begin
         send_item(directed[i].drain, directed[i].px, got, res);
         if (directed[i].check == CHK_NONE && got)
            note_error($sformatf("row %0d should give no pixel", i));
         if (directed[i].check == CHK_TYPED && (!got || res !== directed[i].want))
            note_error($sformatf("row %0d exp %h got %b %h", i, directed[i].want, got, res));
      end

      // extreme sizes, clamped values included, one frame with no idling
      set_frame(0, 0);
      run_frame();
      run_frame();
      steady = 1'b1;
      set_frame(48, 4);
      run_frame();
      steady = 1'b0;
      set_frame(2, 1);
      run_frame();
      set_frame(1, 2);
      run_frame();

      // random sizes, mostly small
      rand_start = item_count;
      while (item_count - rand_start < RANDOM_ITEMS) begin
         case ($urandom_range(19))
            0:       w = $urandom_range(1) ? 0 : 1;
            1, 2, 3: w = $urandom_range(9, 48);
            default: w = $urandom_range(1, 8);
         endcase
         case ($urandom_range(19))
            0:       h = 0;
            1, 2:    h = $urandom_range(7, 12);
            default: h = $urandom_range(1, 6);
         endcase
         set_frame(w, h);
         repeat ($urandom_range(1, 3)) begin
            if (item_count - rand_start < RANDOM_ITEMS) run_frame();
         end
      end

      req_tvalid <= 1'b0;
      while (blurred_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("box_blur_3x3_edge_aware_core_test: done, clean");
      else
         $display("box_blur_3x3_edge_aware_core_test: done, errors");
      $finish;
   end

endmodule
